@@ hw/rtl/spq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Transaction payload structs, opcode and status codes, default sizes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH_DEF    = 16;
    localparam int SPQ_TAG_BITS_DEF = 8;
    localparam int SPQ_PRIO_W       = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic                  opcode;
        logic [SPQ_PRIO_W-1:0] key_priority;
        logic [7:0]            item_tag;
    } spq_cmd_t;

    typedef struct packed {
        spq_status_t status;
        logic        front_valid;
        logic [7:0]  front_tag;
        logic [4:0]  entry_count;
    } spq_rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/spq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_priority_queue_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted-list priority queue over one RAM
// Entries are kept in a circular buffer in priority order; dequeue advances
// the head, enqueue shifts the tail one entry per cycle to open a slot.
// ----------------------------------------------------------------------------
// Steps, start accepted to done strobe:
//   enqueue into empty or full queue: done straight from idle, next transaction right away
//   dequeue: one RAM read in ST_DEQ, then done; dequeue on empty: done straight from idle
//   other enqueue: ST_SCAN shifts each entry behind the insertion point,
//   one RAM read-compare-write per cycle, then writes the new entry.
// The receiver cannot stall. Reset empties the queue; RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH    = SPQ_DEPTH_DEF,
    parameter int TAG_BITS = SPQ_TAG_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire spq_cmd_t cmd,
    output logic          busy,
    output logic          done,
    output spq_rsp_t      rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = SPQ_PRIO_W + TAG_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FRONT,
        ST_DEQ
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         j_reg, j_next;
    logic [SPQ_PRIO_W-1:0] prio_reg, prio_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic                  done_reg, done_next;
    spq_rsp_t              rsp_reg, rsp_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    logic [SPQ_PRIO_W-1:0] rd_prio;
    logic [TAG_BITS-1:0]   rd_tag;
    logic [TAG_BITS-1:0]   in_tag;
    logic [31:0]           in_tag_ext;
    logic [31:0]           out_tag_ext;
    logic                  shift;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [4:0] count5(input logic [CW-1:0] c);
        logic [31:0] w;
        w = '0;
        w[CW-1:0] = c;
        return w[4:0];
    endfunction

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_prio = ram_rdata[TAG_BITS +: SPQ_PRIO_W];
    assign rd_tag  = ram_rdata[TAG_BITS-1:0];

    always_comb
    begin
        in_tag_ext = '0;
        in_tag_ext[7:0] = cmd.item_tag;
        in_tag = in_tag_ext[TAG_BITS-1:0];
        out_tag_ext = '0;
        out_tag_ext[TAG_BITS-1:0] = rd_tag;
    end

    // ascending order; a new key goes ahead of equal keys, but stays behind an equal front
    assign shift = (j_reg == '0) ? (prio_reg < rd_prio) : (prio_reg <= rd_prio);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        head_next  = head_reg;
        j_next     = j_reg;
        prio_next  = prio_reg;
        tag_next   = tag_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        ram_wdata  = {prio_reg, tag_reg};
        ram_raddr  = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rsp_next.front_valid = 1'b0;
                    rsp_next.front_tag   = '0;
                    rsp_next.status      = STATUS_DONE;
                    if (cmd.opcode == OP_ENQ)
                    begin
                        prio_next = cmd.key_priority;
                        tag_next  = in_tag;
                        if (count_reg == CW'(DEPTH))
                        begin
                            rsp_next.status = STATUS_FULL;
                            done_next       = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = head_reg;
                            ram_wdata  = {cmd.key_priority, in_tag};
                            count_next = CW'(1);
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            j_next     = AW'(count_reg - CW'(1));
                            ram_raddr  = phys(head_reg, AW'(count_reg - CW'(1)));
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = STATUS_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            state_next = ST_DEQ;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, j_reg + AW'(1));
                if (shift)
                begin
                    ram_wdata = ram_rdata;
                    if (j_reg == '0)
                    begin
                        state_next = ST_FRONT;
                    end
                    else
                    begin
                        j_next    = j_reg - AW'(1);
                        ram_raddr = phys(head_reg, j_reg - AW'(1));
                    end
                end
                else
                begin
                    ram_wdata  = {prio_reg, tag_reg};
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FRONT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_reg;
                ram_wdata  = {prio_reg, tag_reg};
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_DEQ:
            begin
                rsp_next.status      = STATUS_DONE;
                rsp_next.front_valid = 1'b1;
                rsp_next.front_tag   = out_tag_ext[7:0];
                head_next            = phys(head_reg, AW'(1));
                count_next           = count_reg - CW'(1);
                done_next            = 1'b1;
                state_next           = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next.entry_count = count5(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            j_reg     <= '0;
            prio_reg  <= '0;
            tag_reg   <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            j_reg     <= j_next;
            prio_reg  <= prio_next;
            tag_reg   <= tag_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STATUS_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full reported with free slots");

    a_front_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.front_valid) |-> (rsp.status == STATUS_DONE))
        else $error("payload returned with error status");

    a_deq_read: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode == OP_DEQ && count_reg != '0)
            |=> (state_reg == ST_DEQ))
        else $error("dequeue did not start RAM read");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != '0 && count_reg != CW'(DEPTH)))
        else $error("insert scan with empty or full queue");

endmodule
`default_nettype wire
